// ===== src/ps2kd_pkg.sv =====
// ps2kd_pkg: types, codes and scancode tables of the ps/2 set 2 key decoder
`default_nettype none

package ps2kd_pkg;

    // prefix bytes
    localparam logic [7:0] SC_EXT   = 8'hE0;
    localparam logic [7:0] SC_BREAK = 8'hF0;
    localparam logic [7:0] SC_PAUSE = 8'hE1;

    // dense key numbers of the modifier keys, of f1 and f12, and of no key
    localparam logic [6:0] KEY_NONE   = 7'd0;
    localparam logic [6:0] KEY_LSHIFT = 7'd61;
    localparam logic [6:0] KEY_RSHIFT = 7'd62;
    localparam logic [6:0] KEY_LCTRL  = 7'd63;
    localparam logic [6:0] KEY_LALT   = 7'd64;
    localparam logic [6:0] KEY_RCTRL  = 7'd96;
    localparam logic [6:0] KEY_RALT   = 7'd97;
    localparam logic [6:0] KEY_F1     = 7'd1;
    localparam logic [6:0] KEY_F12    = 7'd12;

    // modifier bit masks
    localparam logic [5:0] MOD_SHIFT = 6'h03;
    localparam logic [5:0] MOD_CTRL  = 6'h0C;
    localparam logic [5:0] MOD_ALT   = 6'h30;

    // configuration register index, taken from paddr[2]
    localparam logic REG_GUI_ACTIVE = 1'b0;

    typedef enum logic [3:0] {
        PFX_IDLE      = 4'b0001,
        PFX_BREAK     = 4'b0010,
        PFX_EXT       = 4'b0100,
        PFX_EXT_BREAK = 4'b1000
    } prefix_state_t;

    typedef struct packed {
        prefix_state_t prefix;
        logic [5:0]    mods;
    } dec_state_t;

    typedef struct packed {
        logic [6:0] key_code;
        logic       pressed;
        logic [5:0] modifiers;
        logic       to_gui;
        logic [3:0] fkey_number;
        logic       ctrl_held;
        logic       alt_held;
        logic       shift_held;
    } key_event_t;

    function automatic logic [6:0] normal_map(input logic [7:0] b);
        logic [6:0] k;
        k = KEY_NONE;
        case (b)
            8'h05: k = 7'd1;   8'h06: k = 7'd2;   8'h04: k = 7'd3;   8'h0C: k = 7'd4;
            8'h03: k = 7'd5;   8'h0B: k = 7'd6;   8'h83: k = 7'd7;   8'h0A: k = 7'd8;
            8'h01: k = 7'd9;   8'h09: k = 7'd10;  8'h78: k = 7'd11;  8'h07: k = 7'd12;
            8'h16: k = 7'd13;  8'h1E: k = 7'd14;  8'h26: k = 7'd15;  8'h25: k = 7'd16;
            8'h2E: k = 7'd17;  8'h36: k = 7'd18;  8'h3D: k = 7'd19;  8'h3E: k = 7'd20;
            8'h46: k = 7'd21;  8'h45: k = 7'd22;  8'h4E: k = 7'd23;  8'h55: k = 7'd24;
            8'h66: k = 7'd25;
            8'h15: k = 7'd26;  8'h1D: k = 7'd27;  8'h24: k = 7'd28;  8'h2D: k = 7'd29;
            8'h2C: k = 7'd30;  8'h35: k = 7'd31;  8'h3C: k = 7'd32;  8'h43: k = 7'd33;
            8'h44: k = 7'd34;  8'h4D: k = 7'd35;  8'h54: k = 7'd36;  8'h5B: k = 7'd37;
            8'h5D: k = 7'd38;
            8'h1C: k = 7'd39;  8'h1B: k = 7'd40;  8'h23: k = 7'd41;  8'h2B: k = 7'd42;
            8'h34: k = 7'd43;  8'h33: k = 7'd44;  8'h3B: k = 7'd45;  8'h42: k = 7'd46;
            8'h4B: k = 7'd47;  8'h4C: k = 7'd48;  8'h52: k = 7'd49;  8'h5A: k = 7'd50;
            8'h1A: k = 7'd51;  8'h22: k = 7'd52;  8'h21: k = 7'd53;  8'h2A: k = 7'd54;
            8'h32: k = 7'd55;  8'h31: k = 7'd56;  8'h3A: k = 7'd57;  8'h41: k = 7'd58;
            8'h49: k = 7'd59;  8'h4A: k = 7'd60;
            8'h12: k = 7'd61;  8'h59: k = 7'd62;  8'h14: k = 7'd63;  8'h11: k = 7'd64;
            8'h0D: k = 7'd65;  8'h76: k = 7'd66;  8'h29: k = 7'd67;  8'h58: k = 7'd68;
            8'h70: k = 7'd69;  8'h69: k = 7'd70;  8'h72: k = 7'd71;  8'h7A: k = 7'd72;
            8'h6B: k = 7'd73;  8'h73: k = 7'd74;  8'h74: k = 7'd75;  8'h6C: k = 7'd76;
            8'h75: k = 7'd77;  8'h7D: k = 7'd78;  8'h79: k = 7'd79;  8'h7B: k = 7'd80;
            8'h7C: k = 7'd81;  8'h71: k = 7'd82;  8'h77: k = 7'd83;  8'h7E: k = 7'd84;
            8'h84: k = 7'd85;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] extended_map(input logic [7:0] b);
        logic [6:0] k;
        k = KEY_NONE;
        case (b)
            8'h75: k = 7'd86;  8'h72: k = 7'd87;  8'h6B: k = 7'd88;  8'h74: k = 7'd89;
            8'h70: k = 7'd90;  8'h71: k = 7'd91;  8'h6C: k = 7'd92;  8'h69: k = 7'd93;
            8'h7D: k = 7'd94;  8'h7A: k = 7'd95;  8'h14: k = 7'd96;  8'h11: k = 7'd97;
            8'h1F: k = 7'd98;  8'h27: k = 7'd99;  8'h2F: k = 7'd100; 8'h4A: k = 7'd101;
            8'h5A: k = 7'd102; 8'h7C: k = 7'd85;  8'h7E: k = 7'd103;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] modifier_mask(input logic [6:0] key);
        logic [5:0] m;
        m = 6'h00;
        case (key)
            KEY_LSHIFT: m = 6'h01;
            KEY_RSHIFT: m = 6'h02;
            KEY_LCTRL:  m = 6'h04;
            KEY_RCTRL:  m = 6'h08;
            KEY_LALT:   m = 6'h10;
            KEY_RALT:   m = 6'h20;
            default:    m = 6'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/ps2kd_decode.sv =====
// ps2kd_decode: prefix machine step, table lookup and event build for one scancode byte
`default_nettype none

module ps2kd_decode (
    input  wire logic [7:0]            scan_byte,
    input  wire logic                  gui_active,
    input  wire ps2kd_pkg::dec_state_t cur,
    output ps2kd_pkg::dec_state_t      nxt,
    output logic                       emit,
    output ps2kd_pkg::key_event_t      evt
);
    import ps2kd_pkg::*;

    logic [6:0] key;
    logic       press;
    logic [5:0] mask;
    logic [5:0] mods_upd;

    always_comb
    begin
        nxt   = cur;
        key   = KEY_NONE;
        press = 1'b1;
        unique case (cur.prefix)
            PFX_IDLE:
            begin
                if (scan_byte == SC_EXT)
                begin
                    nxt.prefix = PFX_EXT;
                end
                else if (scan_byte == SC_BREAK)
                begin
                    nxt.prefix = PFX_BREAK;
                end
                else if (scan_byte != SC_PAUSE)
                begin
                    key = normal_map(scan_byte);
                end
            end
            PFX_BREAK:
            begin
                nxt.prefix = PFX_IDLE;
                key        = normal_map(scan_byte);
                press      = 1'b0;
            end
            PFX_EXT:
            begin
                if (scan_byte == SC_BREAK)
                begin
                    nxt.prefix = PFX_EXT_BREAK;
                end
                else
                begin
                    nxt.prefix = PFX_IDLE;
                    key        = extended_map(scan_byte);
                end
            end
            PFX_EXT_BREAK:
            begin
                nxt.prefix = PFX_IDLE;
                key        = extended_map(scan_byte);
                press      = 1'b0;
            end
            default:
            begin
                nxt.prefix = PFX_IDLE;
            end
        endcase

        mask     = modifier_mask(key);
        mods_upd = press ? (cur.mods | mask) : (cur.mods & ~mask);
        if (key != KEY_NONE)
        begin
            nxt.mods = mods_upd;
        end

        // gui mode swallows releases
        emit = (key != KEY_NONE) && (press || !gui_active);

        evt             = '0;
        evt.key_code    = key;
        evt.pressed     = press;
        evt.modifiers   = mods_upd;
        evt.to_gui      = gui_active;
        if (!gui_active && key >= KEY_F1 && key <= KEY_F12)
        begin
            evt.fkey_number = key[3:0];
            evt.ctrl_held   = |(mods_upd & MOD_CTRL);
            evt.alt_held    = |(mods_upd & MOD_ALT);
            evt.shift_held  = |(mods_upd & MOD_SHIFT);
        end
    end

endmodule

`default_nettype wire

// ===== src/ps2_scancode_key_decoder_unit.sv =====
// ps2_scancode_key_decoder_unit: top level of the ps/2 set 2 scancode to key event decoder
`default_nettype none

// channel   direction  handshake            payload
// input     in         in_valid / in_ready  scan_byte[7:0]
// output    out        out_valid/out_ready  key_code, pressed, modifiers, to_gui,
//                                           fkey_number, ctrl_held, alt_held, shift_held
// config    in         apb write/read       gui_active at byte address 0
//
// one item per cycle while the output is not stalled; an accepted byte sits in the input
// register and its event is then written from there into the result register
// prefix bytes, lone e1, unmapped codes and gui releases give no result
// reset clears prefix state, modifiers, gui_active and both valid flags
// a stalled output holds the input register; in_ready drops only then

module ps2_scancode_key_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // apb configuration port
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    // scancode input
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] scan_byte,
    // key event output
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      key_code,
    output logic            pressed,
    output logic [5:0]      modifiers,
    output logic            to_gui,
    output logic [3:0]      fkey_number,
    output logic            ctrl_held,
    output logic            alt_held,
    output logic            shift_held
);
    import ps2kd_pkg::*;

    logic       gui_active_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // decoder state, updated as the input register item is consumed
    dec_state_t state_reg;
    dec_state_t state_next;

    // result register
    logic       out_valid_reg;
    key_event_t out_evt_reg;

    logic       dec_emit;
    key_event_t dec_evt;
    logic       advance;

    // --- configuration port ---
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gui_active_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_GUI_ACTIVE))
        begin
            gui_active_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GUI_ACTIVE)
        begin
            prdata[0] = gui_active_reg;
        end
    end

    // --- flow control ---
    // the input register item moves on when the result register is free or
    // is being emptied this cycle, whether or not the item makes an event
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= scan_byte;
        end
    end

    // --- decode ---
    ps2kd_decode u_decode (
        .scan_byte  (in_byte_reg),
        .gui_active (gui_active_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .emit       (dec_emit),
        .evt        (dec_evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prefix <= PFX_IDLE;
            state_reg.mods   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // --- result register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dec_emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_emit)
        begin
            out_evt_reg <= dec_evt;
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_code    = out_evt_reg.key_code;
    assign pressed     = out_evt_reg.pressed;
    assign modifiers   = out_evt_reg.modifiers;
    assign to_gui      = out_evt_reg.to_gui;
    assign fkey_number = out_evt_reg.fkey_number;
    assign ctrl_held   = out_evt_reg.ctrl_held;
    assign alt_held    = out_evt_reg.alt_held;
    assign shift_held  = out_evt_reg.shift_held;

endmodule

`default_nettype wire

// ===== bench/ps2_scancode_key_decoder_unit_test.sv =====
// self-checking testbench of the ps/2 set 2 scancode key decoder
`timescale 1ns / 100ps

module ps2_scancode_key_decoder_unit_test;

    import ps2kd_pkg::*;

    // byte address of the gui_active register (register 0, 32-bit spacing)
    localparam logic [2:0] ADDR_GUI_ACTIVE = 3'd0;

    // scancodes of the modifier keys and of numlock, used to build sequences
    localparam logic [7:0] SC_SHIFT_L = 8'h12;
    localparam logic [7:0] SC_SHIFT_R = 8'h59;
    localparam logic [7:0] SC_CTRL    = 8'h14;
    localparam logic [7:0] SC_ALT     = 8'h11;
    localparam logic [7:0] SC_NUMLOCK = 8'h77;

    // print key, reachable both plain and behind e0
    localparam logic [6:0] KEY_PRINT     = 7'd85;
    // first key number of the extended block
    localparam logic [6:0] KEY_EXT_FIRST = 7'd86;

    // plain scancodes listed in key number order, key 1 first
    localparam logic [0:84][7:0] PLAIN_CODES = {
        8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h78, 8'h07,
        8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45, 8'h4E, 8'h55,
        8'h66,
        8'h15, 8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h54, 8'h5B,
        8'h5D,
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h4B, 8'h4C, 8'h52, 8'h5A,
        8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32, 8'h31, 8'h3A, 8'h41, 8'h49, 8'h4A,
        8'h12, 8'h59, 8'h14, 8'h11, 8'h0D, 8'h76, 8'h29, 8'h58,
        8'h70, 8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D,
        8'h79, 8'h7B, 8'h7C, 8'h71, 8'h77, 8'h7E, 8'h84
    };

    // codes behind e0 in key number order from 86 up; the last one is print
    localparam logic [0:18][7:0] EXT_CODES = {
        8'h75, 8'h72, 8'h6B, 8'h74, 8'h70, 8'h71, 8'h6C, 8'h69, 8'h7D, 8'h7A,
        8'h14, 8'h11, 8'h1F, 8'h27, 8'h2F, 8'h4A, 8'h5A, 8'h7E, 8'h7C
    };

    // directed opening: byte extremes, f-keys with and without modifiers,
    // e0 after e0, prefix after f0, lone e1, both print keys, releases
    localparam logic [0:24][7:0] OPENING_BYTES = {
        8'h00, 8'hFF, 8'h05, 8'h14, 8'hE0, 8'h11, 8'h12, 8'h07, 8'hF0, 8'h07,
        8'hE0, 8'h7C, 8'hE0, 8'hF0, 8'h11, 8'hE0, 8'hE0, 8'hF0, 8'hE0, 8'hE1,
        8'h84, 8'hF0, 8'h12, 8'hF0, 8'h14
    };

    localparam int PHASE_COUNT     = 6;
    localparam int BYTES_PER_PHASE = 280;
    localparam int DRAIN_CYCLES    = 4;      // input register plus result register, with margin
    localparam int WATCHDOG_LIMIT  = 2000;   // far above the longest gap or stall

    // clock, reset and dut ports
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  scan_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  key_code;
    logic        pressed;
    logic [5:0]  modifiers;
    logic        to_gui;
    logic [3:0]  fkey_number;
    logic        ctrl_held;
    logic        alt_held;
    logic        shift_held;

    // decoder state as the bench sees it
    logic [6:0]    plain_key_of [256];
    logic [6:0]    ext_key_of   [256];
    prefix_state_t dec_prefix = PFX_IDLE;
    logic [5:0]    held_mods  = '0;
    logic          gui_mode   = 1'b0;

    logic [7:0]    scan_bytes_to_send [$];
    key_event_t    expected_key_events [$];
    key_event_t    oldest_event;
    logic          in_fire = 1'b0;
    int            failures = 0;
    int            send_gap = 0;
    int            sender_burst = 0;
    int            stall_left = 0;
    int            receiver_burst = 0;

    ps2_scancode_key_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_code    (key_code),
        .pressed     (pressed),
        .modifiers   (modifiers),
        .to_gui      (to_gui),
        .fkey_number (fkey_number),
        .ctrl_held   (ctrl_held),
        .alt_held    (alt_held),
        .shift_held  (shift_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // byte to key lookup, built from the code lists above
    initial
    begin
        for (int b = 0; b < 256; b++)
        begin
            plain_key_of[b] = KEY_NONE;
            ext_key_of[b]   = KEY_NONE;
        end
        for (int k = 0; k < 85; k++)
            plain_key_of[PLAIN_CODES[k]] = 7'(k + 1);
        for (int k = 0; k < 18; k++)
            ext_key_of[EXT_CODES[k]] = 7'(KEY_EXT_FIRST + k);
        ext_key_of[EXT_CODES[18]] = KEY_PRINT;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // advance the prefix machine by one byte and queue the event it causes
    task automatic decode_scan_byte(input logic [7:0] b);
        logic [6:0] key;
        logic       make;
        logic [5:0] mask;
        key_event_t ev;
        key  = KEY_NONE;
        make = 1'b0;
        case (dec_prefix)
            PFX_IDLE:
                if (b == SC_EXT)
                    dec_prefix = PFX_EXT;
                else if (b == SC_BREAK)
                    dec_prefix = PFX_BREAK;
                else if (b != SC_PAUSE)
                begin
                    // lone e1 is dropped, anything else is a plain make
                    key  = plain_key_of[b];
                    make = 1'b1;
                end
            PFX_BREAK:
            begin
                // any byte ends the break state, prefixes just miss the table
                dec_prefix = PFX_IDLE;
                key        = plain_key_of[b];
            end
            PFX_EXT:
                if (b == SC_BREAK)
                    dec_prefix = PFX_EXT_BREAK;
                else
                begin
                    // e0 after e0 misses the extended table
                    dec_prefix = PFX_IDLE;
                    key        = ext_key_of[b];
                    make       = 1'b1;
                end
            default:
            begin
                dec_prefix = PFX_IDLE;
                key        = ext_key_of[b];
            end
        endcase
        if (key == KEY_NONE)
            return;

        case (key)
            KEY_LSHIFT: mask = 6'h01;
            KEY_RSHIFT: mask = 6'h02;
            KEY_LCTRL:  mask = 6'h04;
            KEY_RCTRL:  mask = 6'h08;
            KEY_LALT:   mask = 6'h10;
            KEY_RALT:   mask = 6'h20;
            default:    mask = 6'h00;
        endcase
        held_mods = make ? (held_mods | mask) : (held_mods & ~mask);

        ev           = '0;
        ev.key_code  = key;
        ev.pressed   = make;
        ev.modifiers = held_mods;
        if (gui_mode)
        begin
            // gui swallows releases, modifiers were still updated above
            if (make)
            begin
                ev.to_gui = 1'b1;
                expected_key_events.push_back(ev);
            end
        end
        else
        begin
            if (key >= KEY_F1 && key <= KEY_F12)
            begin
                ev.fkey_number = key[3:0];
                ev.ctrl_held   = |(held_mods & MOD_CTRL);
                ev.alt_held    = |(held_mods & MOD_ALT);
                ev.shift_held  = |(held_mods & MOD_SHIFT);
            end
            expected_key_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
        end
    endtask

    // output checker and input predictor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_key_events.size() == 0)
                begin
                    $error("key event with none expected: key_code %0d pressed %0d",
                           key_code, pressed);
                    failures++;
                end
                else
                begin
                    oldest_event = expected_key_events.pop_front();
                    check_field("key_code", 32'(oldest_event.key_code), 32'(key_code));
                    check_field("pressed", 32'(oldest_event.pressed), 32'(pressed));
                    check_field("modifiers", 32'(oldest_event.modifiers), 32'(modifiers));
                    check_field("to_gui", 32'(oldest_event.to_gui), 32'(to_gui));
                    check_field("fkey_number", 32'(oldest_event.fkey_number),
                                32'(fkey_number));
                    check_field("ctrl_held", 32'(oldest_event.ctrl_held), 32'(ctrl_held));
                    check_field("alt_held", 32'(oldest_event.alt_held), 32'(alt_held));
                    check_field("shift_held", 32'(oldest_event.shift_held),
                                32'(shift_held));
                end
            end
            if (in_valid && in_ready)
                decode_scan_byte(scan_byte);
        end
        in_fire <= rst_n && in_valid && in_ready;
    end

    // scancode driver: holds an item until taken, then waits out a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;   // item still waiting, payload stays put
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap--;
        end
        else if (scan_bytes_to_send.size() > 0)
        begin
            in_valid  <= 1'b1;
            scan_byte <= scan_bytes_to_send.pop_front();
            // gap before the next item, with bursts of back-to-back items
            if (sender_burst > 0)
                sender_burst--;
            else if ($urandom_range(0, 99) < 2)
                sender_burst = $urandom_range(40, 120);
            else if ($urandom_range(0, 99) < 35)
                send_gap = idle_length();
        end
        else
            in_valid <= 1'b0;
    end

    // result sink: random stalls with stretches of no stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (receiver_burst > 0)
                receiver_burst--;
            else if ($urandom_range(0, 99) < 2)
                receiver_burst = $urandom_range(40, 120);
            else if ($urandom_range(0, 99) < 30)
                stall_left = idle_length();
        end
    end

    // ends the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic queue_byte(input logic [7:0] b);
        scan_bytes_to_send.push_back(b);
    endtask

    // sender empty and every expected event delivered
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (scan_bytes_to_send.size() != 0 || in_valid
               || expected_key_events.size() != 0);
    endtask

    // apb write of gui_active while idle, then a read back
    task automatic write_gui_active(input logic value);
        wait_quiet();
        // a trailing byte that gives no result may still sit in the pipe
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GUI_ACTIVE;
        pwdata  <= {31'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        gui_mode = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("gui_active", {31'b0, value}, {31'b0, prdata[0]});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random keystroke or piece of noise; returns how many bytes were queued
    task automatic queue_keystroke(output int count);
        int         pick;
        logic       brk;
        logic [7:0] code;
        pick  = $urandom_range(0, 99);
        brk   = 1'($urandom_range(0, 1));
        count = scan_bytes_to_send.size();
        if (pick < 38)
        begin
            // plain key make or break
            code = PLAIN_CODES[$urandom_range(0, 84)];
            if (brk)
                queue_byte(SC_BREAK);
            queue_byte(code);
        end
        else if (pick < 53)
        begin
            // extended key make or break
            code = EXT_CODES[$urandom_range(0, 18)];
            queue_byte(SC_EXT);
            if (brk)
                queue_byte(SC_BREAK);
            queue_byte(code);
        end
        else if (pick < 65)
        begin
            // one of the six modifiers, right ctrl and alt behind e0
            case ($urandom_range(0, 5))
                0: code = SC_SHIFT_L;
                1: code = SC_SHIFT_R;
                2, 4: code = SC_CTRL;
                default: code = SC_ALT;
            endcase
            if (code != SC_SHIFT_L && code != SC_SHIFT_R && $urandom_range(0, 1))
                queue_byte(SC_EXT);
            if (brk)
                queue_byte(SC_BREAK);
            queue_byte(code);
        end
        else if (pick < 73)
        begin
            // function key, so the held flags get exercised
            code = PLAIN_CODES[$urandom_range(0, 11)];
            if (brk)
                queue_byte(SC_BREAK);
            queue_byte(code);
        end
        else if (pick < 77)
        begin
            // pause: lone e1 dropped, rest decodes as ctrl and numlock
            queue_byte(SC_PAUSE);
            queue_byte(SC_CTRL);
            queue_byte(SC_NUMLOCK);
            queue_byte(SC_PAUSE);
            queue_byte(SC_BREAK);
            queue_byte(SC_CTRL);
            queue_byte(SC_BREAK);
            queue_byte(SC_NUMLOCK);
        end
        else if (pick < 89)
            queue_byte(8'($urandom_range(0, 255)));
        else
        begin
            // broken sequence: stray prefixes then any byte
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 2))
                    0: queue_byte(SC_EXT);
                    1: queue_byte(SC_BREAK);
                    default: queue_byte(SC_PAUSE);
                endcase
            end
            queue_byte(8'($urandom_range(0, 255)));
        end
        count = scan_bytes_to_send.size() - count;
    endtask

    // reset, configuration phases and stimulus
    initial
    begin : sequencer
        int queued;
        int added;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening with the keyboard path
        write_gui_active(1'b0);
        for (int i = 0; i < 25; i++)
            queue_byte(OPENING_BYTES[i]);

        // random phases alternate gui routing on and off
        for (int p = 1; p <= PHASE_COUNT; p++)
        begin
            write_gui_active(p[0]);
            queued = 0;
            while (queued < BYTES_PER_PHASE)
            begin
                queue_keystroke(added);
                queued += added;
                // sender holds back until every expected event is out
                if (queued >= BYTES_PER_PHASE / 2 && queued - added < BYTES_PER_PHASE / 2)
                    wait_quiet();
                // keep only a modest backlog so gaps stay random
                while (scan_bytes_to_send.size() > 16)
                    @(posedge clk);
            end
        end

        wait_quiet();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (expected_key_events.size() != 0)
        begin
            $error("%0d key events never arrived", expected_key_events.size());
            failures++;
        end
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ps2kd_pkg.sv
src/ps2kd_decode.sv
src/ps2_scancode_key_decoder_unit.sv
bench/ps2_scancode_key_decoder_unit_test.sv
